FILE: hdl/kstc_pkg.sv
// -----------------------------------------------------------------------------
// Keyed session ticket cache package
// Shared types, codes and defaults for the session ticket cache.
// -----------------------------------------------------------------------------
`default_nettype none

package kstc_pkg;

	localparam int IDENTITIES_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int LIMIT_W         = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
	localparam int KEY_W           = 256;

	localparam logic [1:0] CMD_TAKE  = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] KIND_GRANT   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_MISS    = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [31:0] session_handle;
		logic [39:0] expiry_time;
		logic [39:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] handle_out;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [39:0] expiry;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MISSING,
		ST_LOAD,
		ST_ADD_CHK,
		ST_DROP_WAIT,
		ST_APPEND,
		ST_POP,
		ST_POP_WAIT,
		ST_FULL_REL,
		ST_FINISH
	} kstc_state_t;

endpackage

`default_nettype wire

FILE: hdl/kstc_ram.sv
// -----------------------------------------------------------------------------
// Session cache RAM
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module kstc_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/kstc_ctrl.sv
// -----------------------------------------------------------------------------
// Session cache sequencer
// Searches the key store, walks the handle rings and issues results.
// -----------------------------------------------------------------------------
`default_nettype none

module kstc_ctrl import kstc_pkg::*; #(
	parameter int IDENTITIES  = IDENTITIES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [CW-1:0] limit,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire in_item_t      in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output out_item_t          out_data
);

	localparam int IDW = (IDENTITIES > 1) ? $clog2(IDENTITIES) : 1;
	localparam int NW  = $clog2(IDENTITIES + 1);
	localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SD  = IDENTITIES * QUEUE_DEPTH;
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
	localparam int MW  = HW + CW;
	localparam int SW  = $bits(slot_t);

	kstc_state_t state_q, state_d;
	in_item_t    req_q;
	logic [IDW-1:0] idx_q, id_q;
	logic [HW-1:0]  head_q, head_next;
	logic [CW-1:0]  count_q;
	logic [NW-1:0]  id_count_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic             key_we, key_re;
	logic [IDW-1:0]   key_waddr, key_raddr;
	logic [KEY_W-1:0] key_rdata, req_key;
	logic             meta_we, meta_re;
	logic [MW-1:0]    meta_wdata, meta_rdata;
	logic             slot_we, slot_re;
	logic [SAW-1:0]   slot_waddr, slot_raddr, slot_base;
	slot_t            slot_wdata, slot_rdata;

	logic            accept, out_free, key_hit, last_idx, full, live, is_take, emit;
	logic [CW:0]     tail_sum;
	logic [HW-1:0]   tail_off;
	out_item_t       emit_item;

	kstc_ram #(.W(KEY_W), .D(IDENTITIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(req_key),
		.re(key_re), .raddr(key_raddr), .rdata(key_rdata)
	);

	kstc_ram #(.W(MW), .D(IDENTITIES)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(id_q), .wdata(meta_wdata),
		.re(meta_re), .raddr(idx_q), .rdata(meta_rdata)
	);

	kstc_ram #(.W(SW), .D(SD)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign req_key   = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
	assign key_hit   = key_rdata == req_key;
	assign last_idx  = (NW'(idx_q) + NW'(1)) == id_count_q;
	assign full      = id_count_q == NW'(IDENTITIES);
	assign live      = slot_rdata.expiry > req_q.now_time;
	assign is_take   = req_q.cmd == CMD_TAKE;
	assign slot_base = SAW'(id_q) * SAW'(QUEUE_DEPTH);
	assign head_next = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_off  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		HW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (id_count_q == '0) ? ST_MISSING : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (key_hit) begin
					state_d = ST_LOAD;
				end else if (last_idx) begin
					state_d = ST_MISSING;
				end
			end
			ST_MISSING: begin
				if (req_q.cmd == CMD_ADD) begin
					state_d = full ? ST_FULL_REL : ST_APPEND;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_LOAD: begin
				if (req_q.cmd == CMD_TAKE || req_q.cmd == CMD_CLEAR) begin
					state_d = ST_POP;
				end else if (req_q.cmd == CMD_ADD) begin
					state_d = ST_ADD_CHK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_ADD_CHK:   state_d = (count_q >= limit) ? ST_DROP_WAIT : ST_APPEND;
			ST_DROP_WAIT: if (out_free) state_d = ST_APPEND;
			ST_APPEND:    if (out_free) state_d = ST_IDLE;
			ST_POP:       state_d = (count_q == '0) ? ST_FINISH : ST_POP_WAIT;
			ST_POP_WAIT: begin
				if (out_free) begin
					state_d = (is_take && live) ? ST_IDLE : ST_POP;
				end
			end
			ST_FULL_REL:  if (out_free) state_d = ST_FINISH;
			ST_FINISH:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory controls and result generation.
	always_comb begin
		in_stall   = state_q != ST_IDLE;
		key_re     = 1'b0;
		key_raddr  = '0;
		key_we     = 1'b0;
		key_waddr  = IDW'(id_count_q);
		meta_re    = 1'b0;
		meta_we    = 1'b0;
		meta_wdata = {head_q, count_q};
		slot_re    = 1'b0;
		slot_raddr = slot_base + SAW'(head_q);
		slot_we    = 1'b0;
		slot_waddr = slot_base + SAW'(tail_off);
		slot_wdata = '{handle: req_q.session_handle, expiry: req_q.expiry_time};
		emit       = 1'b0;
		emit_item  = '{kind: KIND_DONE, handle_out: '0, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				key_re = accept;
			end
			ST_SEARCH: begin
				key_re    = !key_hit && !last_idx;
				key_raddr = idx_q + IDW'(1);
				meta_re   = key_hit;
			end
			ST_MISSING: begin
				key_we = (req_q.cmd == CMD_ADD) && !full;
			end
			ST_ADD_CHK: begin
				slot_re = count_q >= limit;
			end
			ST_DROP_WAIT: begin
				emit      = out_free;
				emit_item = '{kind: KIND_RELEASE, handle_out: slot_rdata.handle, last: 1'b0};
			end
			ST_APPEND: begin
				emit       = out_free;
				slot_we    = out_free;
				meta_we    = out_free;
				meta_wdata = {head_q, count_q + CW'(1)};
			end
			ST_POP: begin
				slot_re = count_q != '0;
				meta_we = count_q == '0;
			end
			ST_POP_WAIT: begin
				emit = out_free;
				if (is_take && live) begin
					meta_we   = out_free;
					emit_item = '{kind: KIND_GRANT, handle_out: slot_rdata.handle, last: 1'b1};
				end else begin
					emit_item = '{kind: KIND_RELEASE, handle_out: slot_rdata.handle, last: 1'b0};
				end
			end
			ST_FULL_REL: begin
				emit      = out_free;
				emit_item = '{kind: KIND_RELEASE, handle_out: req_q.session_handle, last: 1'b0};
			end
			ST_FINISH: begin
				emit      = out_free;
				emit_item = '{kind: is_take ? KIND_MISS : KIND_DONE, handle_out: '0, last: 1'b1};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			id_count_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MISSING && req_q.cmd == CMD_ADD && !full) begin
				id_count_q <= id_count_q + NW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			idx_q <= '0;
		end
		if (state_q == ST_SEARCH) begin
			idx_q <= key_hit ? idx_q : idx_q + IDW'(1);
			id_q  <= idx_q;
		end
		if (state_q == ST_MISSING) begin
			id_q    <= IDW'(id_count_q);
			head_q  <= '0;
			count_q <= '0;
		end
		if (state_q == ST_LOAD) begin
			head_q  <= meta_rdata[MW-1:CW];
			count_q <= meta_rdata[CW-1:0];
		end
		if (slot_re) begin
			head_q  <= head_next;
			count_q <= count_q - CW'(1);
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		id_count_q <= NW'(IDENTITIES))
		else $error("identity fill count beyond table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after an input transfer");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_item.last |=> state_q == ST_IDLE)
		else $error("final result issued but sequencer not idle");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP || state_q == ST_ADD_CHK |-> count_q <= CW'(QUEUE_DEPTH))
		else $error("ring count beyond queue depth");

endmodule

`default_nettype wire

FILE: hdl/keyed_session_ticket_cache_unit.sv
// -----------------------------------------------------------------------------
// Keyed session ticket cache
// Per-identity rings of session handles with expiry, keyed by 256-bit keys.
// -----------------------------------------------------------------------------
// One command is in flight at a time; the next is taken once the previous
// command's final result sits in the output register. A command first scans
// the key RAM one identity per cycle until the key matches or every stored
// identity has been read. Take and clear then pop handles in turn, each with
// a slot RAM read and then the result transfer; add releases the oldest
// handle when the ring is at its limit and then appends. Results wait on the
// output stall without losing the sequencer state.
`default_nettype none

module keyed_session_ticket_cache_unit import kstc_pkg::*; #(
	parameter int IDENTITIES  = IDENTITIES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      eff_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// A zero limit keeps one handle; the limit never exceeds the ring size.
	always_comb begin
		if (limit_q == '0) begin
			eff_limit = CW'(1);
		end else if (int'(limit_q) > QUEUE_DEPTH) begin
			eff_limit = CW'(QUEUE_DEPTH);
		end else begin
			eff_limit = CW'(limit_q);
		end
	end

	kstc_ctrl #(.IDENTITIES(IDENTITIES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .limit(eff_limit),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

`default_nettype wire

FILE: dv/keyed_session_ticket_cache_unit_test.sv
// -----------------------------------------------------------------------------
// Session ticket cache testbench
// Drives take, add and clear commands with random bursts and output stalls,
// predicts every result from a local model of the identity table and handle
// rings, and compares each result transfer in order.
// -----------------------------------------------------------------------------
`default_nettype none

module keyed_session_ticket_cache_unit_test;
	import kstc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NID = IDENTITIES_DEF;
	localparam int QD  = QUEUE_DEPTH_DEF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;

	keyed_session_ticket_cache_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the cache contents.
	logic [LIMIT_W-1:0] limit_reg;
	bit                 id_used [NID];
	logic [255:0]       id_key [NID];
	int                 ring_head [NID];
	int                 ring_count [NID];
	logic [31:0]        ring_handle [NID][QD];
	logic [39:0]        ring_expiry [NID][QD];

	in_item_t  pending_cmds[$];
	out_item_t expected_results[$];
	int        errors = 0;
	bit        long_hold = 1'b0;

	// A small pool of keys so that commands hit stored identities often.
	logic [255:0] key_pool [80];

	function automatic void push_result(logic [1:0] k, logic [31:0] h, logic l);
		out_item_t r;
		r.kind = k;
		r.handle_out = h;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	function automatic int lookup_identity(logic [255:0] key);
		for (int i = 0; i < NID; i++)
			if (id_used[i] && id_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int clamp_limit();
		int l;
		l = limit_reg;
		if (l < 1) l = 1;
		if (l > QD) l = QD;
		return l;
	endfunction

	// Works out the results of one accepted command and updates the cache copy.
	function automatic void predict_cache(in_item_t it);
		logic [255:0] key;
		int           id;
		int           s;
		key = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
		id = lookup_identity(key);
		case (it.cmd)
			CMD_TAKE: begin
				if (id >= 0) begin
					while (ring_count[id] > 0) begin
						s = ring_head[id];
						ring_head[id] = (s + 1) % QD;
						ring_count[id]--;
						if (ring_expiry[id][s] > it.now_time) begin
							push_result(KIND_GRANT, ring_handle[id][s], 1'b1);
							return;
						end
						push_result(KIND_RELEASE, ring_handle[id][s], 1'b0);
					end
				end
				push_result(KIND_MISS, '0, 1'b1);
			end
			CMD_ADD: begin
				if (id < 0) begin
					for (int i = 0; i < NID; i++)
						if (!id_used[i]) begin
							id = i;
							break;
						end
					if (id < 0) begin
						push_result(KIND_RELEASE, it.session_handle, 1'b0);
						push_result(KIND_DONE, '0, 1'b1);
						return;
					end
					id_used[id] = 1'b1;
					id_key[id] = key;
					ring_head[id] = 0;
					ring_count[id] = 0;
				end
				if (ring_count[id] >= clamp_limit()) begin
					s = ring_head[id];
					ring_head[id] = (s + 1) % QD;
					ring_count[id]--;
					push_result(KIND_RELEASE, ring_handle[id][s], 1'b0);
				end
				s = (ring_head[id] + ring_count[id]) % QD;
				ring_handle[id][s] = it.session_handle;
				ring_expiry[id][s] = it.expiry_time;
				ring_count[id]++;
				push_result(KIND_DONE, '0, 1'b1);
			end
			CMD_CLEAR: begin
				if (id >= 0) begin
					while (ring_count[id] > 0) begin
						s = ring_head[id];
						ring_head[id] = (s + 1) % QD;
						ring_count[id]--;
						push_result(KIND_RELEASE, ring_handle[id][s], 1'b0);
					end
				end
				push_result(KIND_DONE, '0, 1'b1);
			end
			default: push_result(KIND_DONE, '0, 1'b1);
		endcase
	endfunction

	// Input transfers are recorded at the rising edge where they happen.
	bit in_taken = 1'b0;
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_cache(in_data);
			void'(pending_cmds.pop_front());
			in_taken = 1'b1;
		end
	end

	// Driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_cmds[0];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with a long hold-off when requested.
	int stall_phase = 0;
	int stall_mode = 0;
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		if (long_hold)
			out_stall <= 1'b1;
		else case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= (stall_phase % 5 < 2);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// Monitor: compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d handle=%h", out_data.kind,
					out_data.handle_out);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
					errors++;
				end
				if (out_data.handle_out !== want.handle_out) begin
					$error("handle_out: expected %h, got %h", want.handle_out,
						out_data.handle_out);
					errors++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_data.last);
					errors++;
				end
			end
		end
	end

	function automatic in_item_t make_cmd(logic [1:0] c, logic [255:0] key,
		logic [31:0] h, logic [39:0] e, logic [39:0] n);
		in_item_t it;
		it.cmd = c;
		{it.key_word3, it.key_word2, it.key_word1, it.key_word0} = key;
		it.session_handle = h;
		it.expiry_time = e;
		it.now_time = n;
		return it;
	endfunction

	function automatic logic [39:0] rand_time();
		return {8'($urandom_range(0, 255)), $urandom()};
	endfunction

	function automatic logic [255:0] rand_key();
		return {$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// Random command on a small key set, times near a moving clock.
	function automatic in_item_t random_cmd(int nkeys, logic [39:0] base);
		logic [1:0]  c;
		int          r;
		logic [39:0] e;
		logic [39:0] n;
		r = $urandom_range(0, 99);
		c = (r < 45) ? CMD_ADD : (r < 85) ? CMD_TAKE : (r < 95) ? CMD_CLEAR : 2'd3;
		e = base + $urandom_range(0, 40) - 20;
		n = base + $urandom_range(0, 40) - 20;
		if ($urandom_range(0, 15) == 0) e = rand_time();
		if ($urandom_range(0, 15) == 0) n = rand_time();
		return make_cmd(c, key_pool[$urandom_range(0, nkeys - 1)], $urandom(), e, n);
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		limit_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [39:0] base;
		logic [LIMIT_W-1:0] limits [6];
		limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8};
		limit_reg = LIMIT_RESET;
		for (int i = 0; i < NID; i++) begin
			id_used[i] = 1'b0;
			ring_head[i] = 0;
			ring_count[i] = 0;
		end
		for (int i = 0; i < 80; i++)
			key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: misses on empty table, expiry equal to now, field extremes,
		// unknown command, clear of absent and present identities.
		pending_cmds.push_back(make_cmd(CMD_TAKE, key_pool[0], '0, '0, '0));
		pending_cmds.push_back(make_cmd(CMD_CLEAR, key_pool[1], '1, '1, '1));
		pending_cmds.push_back(make_cmd(2'd3, key_pool[1], '1, '1, '1));
		pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[0], 32'h0, 40'd100, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[0], '1, '1, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[1], 32'h5a5a_a5a5, '0, '0));
		pending_cmds.push_back(make_cmd(CMD_TAKE, key_pool[0], '0, '0, 40'd100));
		pending_cmds.push_back(make_cmd(CMD_TAKE, key_pool[1], '0, '0, '1));
		pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[1], 32'h1, 40'd5, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[1], 32'h2, 40'd9, '0));
		pending_cmds.push_back(make_cmd(CMD_CLEAR, key_pool[1], '0, '0, '0));
		pending_cmds.push_back(make_cmd(CMD_TAKE, key_pool[0], '0, '0, '1));
		wait_drained();

		// Random phases across limit settings; the first holds the output off.
		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			base = rand_time();
			for (int i = 0; i < 60; i++)
				pending_cmds.push_back(random_cmd(p == 2 ? 3 : 12, base + i * 3));
			if (p == 0) begin
				long_hold = 1'b1;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end
			wait_drained();
		end

		// Fill the identity table so that adds of new keys are turned away.
		for (int i = 0; i < 70; i++)
			pending_cmds.push_back(make_cmd(CMD_ADD, key_pool[i % 80 + (i >= 66 ? 0 : 0)],
				$urandom(), rand_time(), '0));
		for (int i = 0; i < 12; i++)
			pending_cmds.push_back(make_cmd(CMD_ADD, rand_key(), $urandom(), rand_time(), '0));
		for (int i = 0; i < 40; i++)
			pending_cmds.push_back(random_cmd(80, rand_time()));
		wait_drained();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4ms;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
hdl/kstc_pkg.sv
hdl/kstc_ram.sv
hdl/kstc_ctrl.sv
hdl/keyed_session_ticket_cache_unit.sv
dv/keyed_session_ticket_cache_unit_test.sv
